[src/serp_pkg.sv]
package serp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_TIMEOUT_MS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_RETRY_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_FAIL_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_DATA_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRM_FAIL_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNSUPPORTED_LIMIT = 3'd6;

    localparam logic [3:0] EV_CHUNK_OK     = 4'd0;
    localparam logic [3:0] EV_PLAYLIST_OK  = 4'd1;
    localparam logic [3:0] EV_CHUNK_ERR    = 4'd2;
    localparam logic [3:0] EV_PLAYLIST_ERR = 4'd3;
    localparam logic [3:0] EV_FORMAT_OK    = 4'd4;
    localparam logic [3:0] EV_FORMAT_BAD   = 4'd5;
    localparam logic [3:0] EV_DRM_OK       = 4'd6;
    localparam logic [3:0] EV_DRM_ERR      = 4'd7;
    localparam logic [3:0] EV_RESET_REC    = 4'd8;

    localparam logic [1:0] MEDIA_INIT   = 2'd3;
    localparam logic [1:0] REC_PLAYLIST = 2'd3;

    localparam logic [1:0] MODE_VOD  = 2'd0;
    localparam logic [1:0] MODE_LIVE = 2'd1;

    localparam logic [3:0] CODE_NONE    = 4'd0;
    localparam logic [3:0] CODE_CONNECT = 4'd1;

    localparam logic [2:0] V_OK      = 3'd0;
    localparam logic [2:0] V_RETRY   = 3'd1;
    localparam logic [2:0] V_CHUNK   = 3'd2;
    localparam logic [2:0] V_LINK    = 3'd3;
    localparam logic [2:0] V_TIMEOUT = 3'd4;

    localparam logic [10:0] WAIT_NONE    = 11'd0;
    localparam logic [10:0] WAIT_CONNECT = 11'd2000;
    localparam logic [10:0] WAIT_OTHER   = 11'd200;

    localparam logic [31:0] DEFAULT_TIMEOUT = 32'(1000 * 60 * 2);

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [1:0]  media_kind;
        logic [3:0]  error_code;
        logic [31:0] now_ms;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [10:0] retry_interval_ms;
    } t_out_req;

    typedef struct packed {
        logic [1:0]  program_mode;
        logic [31:0] retry_timeout_ms;
        logic [7:0]  chunk_retry_limit;
        logic [7:0]  link_fail_limit;
        logic [7:0]  init_data_limit;
        logic [7:0]  drm_fail_limit;
        logic [7:0]  unsupported_limit;
    } t_cfg;

endpackage

[src/serp_cfg.sv]
module serp_cfg
    import serp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PROGRAM_MODE:      n_cfg.program_mode      = i_cfg_data[1:0];
                REG_RETRY_TIMEOUT_MS:  n_cfg.retry_timeout_ms  = i_cfg_data[31:0];
                REG_CHUNK_RETRY_LIMIT: n_cfg.chunk_retry_limit = i_cfg_data[7:0];
                REG_LINK_FAIL_LIMIT:   n_cfg.link_fail_limit   = i_cfg_data[7:0];
                REG_INIT_DATA_LIMIT:   n_cfg.init_data_limit   = i_cfg_data[7:0];
                REG_DRM_FAIL_LIMIT:    n_cfg.drm_fail_limit    = i_cfg_data[7:0];
                REG_UNSUPPORTED_LIMIT: n_cfg.unsupported_limit = i_cfg_data[7:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.program_mode      <= MODE_VOD;
            r_cfg.retry_timeout_ms  <= DEFAULT_TIMEOUT;
            r_cfg.chunk_retry_limit <= 8'd3;
            r_cfg.link_fail_limit   <= 8'd10;
            r_cfg.init_data_limit   <= 8'd3;
            r_cfg.drm_fail_limit    <= 8'd3;
            r_cfg.unsupported_limit <= 8'd3;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/serp_core.sv]
module serp_core
    import serp_pkg::*;
#(
    parameter int COUNT_BITS = 8,
    parameter int TIME_BITS  = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_req  i_item,
    input  t_cfg     i_cfg,
    output t_out_req o_result
);

    localparam int LW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam int NW = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic [COUNT_BITS-1:0] r_retry [4];
    logic [COUNT_BITS-1:0] r_failed [4];
    logic [3:0]            r_prev [4];
    logic [TIME_BITS-1:0]  r_start [4];
    logic [3:0]            r_start_vld;
    logic [COUNT_BITS-1:0] r_init_cnt;
    logic [COUNT_BITS-1:0] r_drm_cnt;
    logic [COUNT_BITS-1:0] r_unsup_cnt;

    logic [COUNT_BITS-1:0] n_retry [4];
    logic [COUNT_BITS-1:0] n_failed [4];
    logic [3:0]            n_prev [4];
    logic [TIME_BITS-1:0]  n_start [4];
    logic [3:0]            n_start_vld;
    logic [COUNT_BITS-1:0] n_init_cnt;
    logic [COUNT_BITS-1:0] n_drm_cnt;
    logic [COUNT_BITS-1:0] n_unsup_cnt;

    logic [1:0]            rec_idx;
    logic [3:0]            e_code;
    logic [NW-1:0]         now_ext;
    logic [TIME_BITS-1:0]  now_t;
    logic [COUNT_BITS-1:0] rc;
    logic [COUNT_BITS-1:0] fc;
    logic [COUNT_BITS-1:0] rc_inc;
    logic [COUNT_BITS-1:0] fc_inc;
    logic [COUNT_BITS-1:0] init_inc;
    logic [COUNT_BITS-1:0] drm_inc;
    logic [COUNT_BITS-1:0] unsup_inc;
    logic                  chunk_fail;
    logic                  new_run;
    logic [TIME_BITS-1:0]  t_start;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  timeout;

    logic                  e_write;
    logic [COUNT_BITS-1:0] e_rc;
    logic [COUNT_BITS-1:0] e_fc;
    logic [TIME_BITS-1:0]  e_st;
    logic [2:0]            e_v;
    logic [10:0]           e_wait;
    t_out_req              res;

    assign rec_idx = (i_item.event_kind == EV_PLAYLIST_ERR) ? REC_PLAYLIST : i_item.media_kind;
    assign e_code  = (i_item.event_kind == EV_PLAYLIST_ERR) ? CODE_NONE : i_item.error_code;
    assign now_ext = NW'(i_item.now_ms);
    assign now_t   = now_ext[TIME_BITS-1:0];

    assign rc        = r_retry[rec_idx];
    assign fc        = r_failed[rec_idx];
    assign rc_inc    = (rc == CNT_MAX) ? rc : rc + CNT_ONE;
    assign fc_inc    = (fc == CNT_MAX) ? fc : fc + CNT_ONE;
    assign init_inc  = (r_init_cnt == CNT_MAX) ? r_init_cnt : r_init_cnt + CNT_ONE;
    assign drm_inc   = (r_drm_cnt == CNT_MAX) ? r_drm_cnt : r_drm_cnt + CNT_ONE;
    assign unsup_inc = (r_unsup_cnt == CNT_MAX) ? r_unsup_cnt : r_unsup_cnt + CNT_ONE;

    assign chunk_fail = LW'(rc_inc) >= LW'(i_cfg.chunk_retry_limit);
    assign new_run    = r_prev[rec_idx] != e_code;

    // On-demand restarts the clock whenever the error code changes; live starts it once per run.
    assign t_start = (i_cfg.program_mode == MODE_VOD)
                   ? (new_run ? now_t : r_start[rec_idx])
                   : (r_start_vld[rec_idx] ? r_start[rec_idx] : now_t);
    assign elapsed = now_t - t_start;
    assign timeout = NW'(elapsed) >= NW'(i_cfg.retry_timeout_ms);

    always_comb begin
        e_write = 1'b0;
        e_rc    = rc;
        e_fc    = fc;
        e_st    = t_start;
        e_v     = V_OK;
        if (i_cfg.program_mode == MODE_VOD) begin
            e_write = 1'b1;
            if (e_code == CODE_CONNECT) begin
                e_rc = rc_inc;
                e_v  = timeout ? V_TIMEOUT : V_RETRY;
            end else begin
                e_rc = chunk_fail ? '0 : rc_inc;
                e_fc = chunk_fail ? fc_inc : fc;
                e_v  = chunk_fail ? V_CHUNK : V_RETRY;
                if (LW'(e_fc) >= LW'(i_cfg.link_fail_limit)) begin
                    e_fc = COUNT_BITS'(i_cfg.link_fail_limit);
                    e_v  = V_LINK;
                end
            end
        end else if (i_cfg.program_mode == MODE_LIVE) begin
            e_write = 1'b1;
            e_rc    = chunk_fail ? '0 : rc_inc;
            e_fc    = chunk_fail ? fc_inc : fc;
            e_v     = timeout ? V_TIMEOUT : (chunk_fail ? V_CHUNK : V_RETRY);
        end
        if (e_v != V_RETRY || e_code == CODE_NONE) begin
            e_wait = WAIT_NONE;
        end else if (e_code == CODE_CONNECT) begin
            e_wait = WAIT_CONNECT;
        end else begin
            e_wait = WAIT_OTHER;
        end
    end

    always_comb begin
        n_retry     = r_retry;
        n_failed    = r_failed;
        n_prev      = r_prev;
        n_start     = r_start;
        n_start_vld = r_start_vld;
        n_init_cnt  = r_init_cnt;
        n_drm_cnt   = r_drm_cnt;
        n_unsup_cnt = r_unsup_cnt;
        res         = '0;
        unique case (i_item.event_kind)
            EV_CHUNK_OK: begin
                if (i_item.media_kind == MEDIA_INIT) begin
                    n_init_cnt = '0;
                end else begin
                    n_retry[rec_idx]     = '0;
                    n_failed[rec_idx]    = '0;
                    n_prev[rec_idx]      = CODE_NONE;
                    n_start[rec_idx]     = '0;
                    n_start_vld[rec_idx] = 1'b0;
                end
            end
            EV_PLAYLIST_OK: begin
                n_retry[REC_PLAYLIST]     = '0;
                n_failed[REC_PLAYLIST]    = '0;
                n_prev[REC_PLAYLIST]      = CODE_NONE;
                n_start[REC_PLAYLIST]     = '0;
                n_start_vld[REC_PLAYLIST] = 1'b0;
            end
            EV_CHUNK_ERR, EV_PLAYLIST_ERR: begin
                if (i_item.event_kind == EV_CHUNK_ERR && i_item.media_kind == MEDIA_INIT) begin
                    n_init_cnt = init_inc;
                    res.verdict = (LW'(init_inc) > LW'(i_cfg.init_data_limit)) ? V_LINK : V_RETRY;
                end else begin
                    if (e_write) begin
                        n_retry[rec_idx]     = e_rc;
                        n_failed[rec_idx]    = e_fc;
                        n_start[rec_idx]     = e_st;
                        n_start_vld[rec_idx] = r_start_vld[rec_idx] | new_run
                                             | (i_cfg.program_mode == MODE_LIVE);
                        if (i_cfg.program_mode == MODE_VOD) begin
                            n_prev[rec_idx] = e_code;
                        end
                    end
                    res.verdict           = e_v;
                    res.retry_interval_ms = e_wait;
                end
            end
            EV_FORMAT_OK: begin
                n_unsup_cnt = '0;
            end
            EV_FORMAT_BAD: begin
                n_unsup_cnt = unsup_inc;
                res.verdict = (LW'(unsup_inc) >= LW'(i_cfg.unsupported_limit)) ? V_LINK : V_CHUNK;
            end
            EV_DRM_OK: begin
                n_drm_cnt = '0;
            end
            EV_DRM_ERR: begin
                n_drm_cnt = drm_inc;
                if (LW'(drm_inc) >= LW'(i_cfg.drm_fail_limit)) begin
                    res.verdict = V_LINK;
                end else begin
                    res.verdict           = V_RETRY;
                    res.retry_interval_ms = WAIT_OTHER;
                end
            end
            EV_RESET_REC: begin
                for (int i = 0; i < 4; i++) begin
                    n_retry[i]     = '0;
                    n_failed[i]    = '0;
                    n_prev[i]      = CODE_NONE;
                    n_start[i]     = '0;
                    n_start_vld[i] = 1'b0;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_retry[i]  <= '0;
                r_failed[i] <= '0;
                r_prev[i]   <= CODE_NONE;
                r_start[i]  <= '0;
            end
            r_start_vld <= '0;
            r_init_cnt  <= '0;
            r_drm_cnt   <= '0;
            r_unsup_cnt <= '0;
        end else if (i_fire) begin
            r_retry     <= n_retry;
            r_failed    <= n_failed;
            r_prev      <= n_prev;
            r_start     <= n_start;
            r_start_vld <= n_start_vld;
            r_init_cnt  <= n_init_cnt;
            r_drm_cnt   <= n_drm_cnt;
            r_unsup_cnt <= n_unsup_cnt;
        end
    end

    assign o_result = res;

endmodule

[src/stream_error_retry_policy.sv]
// Stream error retry policy.
// The input channel (i_in_valid, o_in_stall, i_in_data) carries one download
// event per request: its kind, media, error code and the current time in ms.
// The output channel (o_out_valid, i_out_stall, o_out_data) returns exactly one
// verdict and retry interval for every request, in order.
// A request in the input register is evaluated against the policy records when
// it fires, and its result is registered in the output register at that edge.
// While the output is not stalled, one request is accepted per cycle; the
// per-record update is combinational between the input and result registers.
// While the receiver stalls, the result is held and one more request can still
// be taken into the input register; after that, o_in_stall goes high.
// The configuration port writes one register per cycle with i_cfg_we; the user
// must use it only while no request is in flight; the block does not enforce it.
// Reset clears both valid flags, all tolerance records and counters, and loads
// the register defaults; o_in_stall is high while reset is asserted.
module stream_error_retry_policy
    import serp_pkg::*;
#(
    parameter int COUNT_BITS = 8,
    parameter int TIME_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_req               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_req              o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic     r_in_valid;
    t_in_req  r_in_data;
    logic     r_out_valid;
    t_out_req r_out_data;
    logic     in_accept;
    logic     fire;
    t_cfg     cfg;
    t_out_req result;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !i_rst_n || (r_in_valid && !fire);
    assign in_accept  = i_in_valid && !o_in_stall;

    serp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    serp_core #(
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
        if (fire) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[src/serp_checker.sv]
module serp_checker
    import serp_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_out_req o_out_data
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.verdict <= V_TIMEOUT)
        else $error("verdict out of range");

    a_wait_only_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.verdict != V_RETRY |-> o_out_data.retry_interval_ms == WAIT_NONE)
        else $error("retry interval given without a retry verdict");

    a_wait_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.retry_interval_ms == WAIT_NONE
                     || o_out_data.retry_interval_ms == WAIT_OTHER
                     || o_out_data.retry_interval_ms == WAIT_CONNECT)
        else $error("unexpected retry interval");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind stream_error_retry_policy serp_checker u_serp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import serp_pkg::*;

    localparam logic [1:0] MEDIA_AUDIO    = 2'd0;
    localparam logic [1:0] MEDIA_VIDEO    = 2'd1;
    localparam logic [1:0] MEDIA_SUBTITLE = 2'd2;
    localparam logic [1:0] MODE_OTHER     = 2'd2;
    localparam logic [1:0] MODE_OTHER_ALT = 2'd3;

    localparam logic [3:0] CODE_SERVER     = 4'd2;
    localparam logic [3:0] CODE_AUTH       = 4'd5;
    localparam logic [3:0] CODE_LAST       = 4'd15;
    localparam logic [3:0] EV_UNUSED_FIRST = 4'd9;
    localparam logic [3:0] EV_UNUSED_LAST  = 4'd15;

    localparam int HOLD_CYCLES     = 150;
    localparam int WATCHDOG_CYCLES = 4000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_req               i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_req              o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    stream_error_retry_policy u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_cfg        policy_regs;
    logic [7:0]  rec_retries[4];
    logic [7:0]  rec_failed_chunks[4];
    logic [3:0]  rec_last_code[4];
    logic [31:0] rec_run_start[4];
    bit          rec_run_started[4];
    logic [7:0]  init_fails;
    logic [7:0]  drm_fails;
    logic [7:0]  format_fails;

    t_out_req    pending_verdicts[$];
    logic [31:0] now_cursor;
    bit          tx_idle_on;
    bit          rx_idle_on;
    int          rx_hold_reqs;
    int          rx_hold_served;
    int          n_sent;
    int          n_checked;
    int          n_settings;
    int          n_err;
    int          quiet_cycles;

    function automatic logic [7:0] sat_up(logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [10:0] wait_for_code(logic [3:0] code);
        if (code == CODE_NONE) return WAIT_NONE;
        if (code == CODE_CONNECT) return WAIT_CONNECT;
        return WAIT_OTHER;
    endfunction

    function automatic void clear_media_record(int r);
        rec_retries[r]       = '0;
        rec_failed_chunks[r] = '0;
        rec_last_code[r]     = CODE_NONE;
        rec_run_start[r]     = '0;
        rec_run_started[r]   = 1'b0;
    endfunction

    function automatic void reset_policy_model();
        policy_regs = '{MODE_VOD, DEFAULT_TIMEOUT, 8'd3, 8'd10, 8'd3, 8'd3, 8'd3};
        for (int r = 0; r < 4; r++) clear_media_record(r);
        init_fails   = '0;
        drm_fails    = '0;
        format_fails = '0;
    endfunction

    function automatic bit run_expired(int r, logic [31:0] now);
        logic [31:0] elapsed;
        elapsed = now - rec_run_start[r];
        return elapsed >= policy_regs.retry_timeout_ms;
    endfunction

    function automatic logic [2:0] count_chunk_error(int r);
        rec_retries[r] = sat_up(rec_retries[r]);
        if (rec_retries[r] >= policy_regs.chunk_retry_limit) begin
            rec_retries[r]       = '0;
            rec_failed_chunks[r] = sat_up(rec_failed_chunks[r]);
            return V_CHUNK;
        end
        return V_RETRY;
    endfunction

    function automatic logic [2:0] media_error(int r, logic [3:0] code, logic [31:0] now);
        logic [2:0] v;
        v = V_OK;
        if (policy_regs.program_mode == MODE_VOD) begin
            if (rec_last_code[r] != code) begin
                rec_run_start[r]   = now;
                rec_run_started[r] = 1'b1;
            end
            rec_last_code[r] = code;
            if (code == CODE_CONNECT) begin
                rec_retries[r] = sat_up(rec_retries[r]);
                v = run_expired(r, now) ? V_TIMEOUT : V_RETRY;
            end else begin
                v = count_chunk_error(r);
                if (rec_failed_chunks[r] >= policy_regs.link_fail_limit) begin
                    rec_failed_chunks[r] = policy_regs.link_fail_limit;
                    v = V_LINK;
                end
            end
        end else if (policy_regs.program_mode == MODE_LIVE) begin
            v = count_chunk_error(r);
            if (!rec_run_started[r]) begin
                rec_run_start[r]   = now;
                rec_run_started[r] = 1'b1;
            end
            if (run_expired(r, now)) v = V_TIMEOUT;
        end
        return v;
    endfunction

    function automatic t_out_req next_verdict(t_in_req req);
        t_out_req res;
        res.verdict           = V_OK;
        res.retry_interval_ms = WAIT_NONE;
        case (req.event_kind)
            EV_CHUNK_OK, EV_CHUNK_ERR: begin
                if (req.media_kind == MEDIA_INIT) begin
                    if (req.event_kind == EV_CHUNK_OK) begin
                        init_fails = '0;
                    end else begin
                        init_fails  = sat_up(init_fails);
                        res.verdict = (init_fails > policy_regs.init_data_limit) ? V_LINK
                                                                                 : V_RETRY;
                    end
                end else if (req.event_kind == EV_CHUNK_OK) begin
                    clear_media_record(int'(req.media_kind));
                end else begin
                    res.verdict = media_error(int'(req.media_kind), req.error_code, req.now_ms);
                    if (res.verdict == V_RETRY) begin
                        res.retry_interval_ms = wait_for_code(req.error_code);
                    end
                end
            end
            EV_PLAYLIST_OK: begin
                clear_media_record(int'(REC_PLAYLIST));
            end
            EV_PLAYLIST_ERR: begin
                res.verdict = media_error(int'(REC_PLAYLIST), CODE_NONE, req.now_ms);
            end
            EV_FORMAT_OK: begin
                format_fails = '0;
            end
            EV_FORMAT_BAD: begin
                format_fails = sat_up(format_fails);
                res.verdict  = (format_fails >= policy_regs.unsupported_limit) ? V_LINK : V_CHUNK;
            end
            EV_DRM_OK: begin
                drm_fails = '0;
            end
            EV_DRM_ERR: begin
                drm_fails = sat_up(drm_fails);
                if (drm_fails >= policy_regs.drm_fail_limit) begin
                    res.verdict = V_LINK;
                end else begin
                    res.verdict           = V_RETRY;
                    res.retry_interval_ms = WAIT_OTHER;
                end
            end
            EV_RESET_REC: begin
                for (int r = 0; r < 4; r++) clear_media_record(r);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [31:0] next_time();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            now_cursor = now_cursor + $urandom_range(0, 3000);
        end else if (pick < 93) begin
            now_cursor = now_cursor + $urandom_range(3000, 40000);
        end else begin
            now_cursor = $urandom();
        end
        return now_cursor;
    endfunction

    function automatic logic [3:0] pick_code();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) return CODE_CONNECT;
        if (pick < 50) return CODE_NONE;
        return 4'($urandom_range(2, 15));
    endfunction

    function automatic t_cfg random_policy(logic [1:0] mode);
        t_cfg c;
        c.program_mode = mode;
        case ($urandom_range(0, 3))
            0:       c.retry_timeout_ms = 32'd1;
            1:       c.retry_timeout_ms = $urandom_range(500, 20000);
            2:       c.retry_timeout_ms = DEFAULT_TIMEOUT;
            default: c.retry_timeout_ms = $urandom_range(20000, 90000);
        endcase
        c.chunk_retry_limit = ($urandom_range(0, 9) == 0) ? 8'd255 : 8'($urandom_range(1, 6));
        c.link_fail_limit   = 8'($urandom_range(1, 4));
        c.init_data_limit   = 8'($urandom_range(0, 5));
        c.drm_fail_limit    = 8'($urandom_range(1, 6));
        c.unsupported_limit = 8'($urandom_range(1, 6));
        return c;
    endfunction

    task automatic send_req(t_in_req req);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_verdicts.push_back(next_verdict(req));
        n_sent++;
        if (tx_idle_on) begin
            gap = idle_len();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_at(logic [3:0] kind, logic [1:0] media, logic [3:0] code,
                           logic [31:0] now);
        t_in_req req;
        req.event_kind = kind;
        req.media_kind = media;
        req.error_code = code;
        req.now_ms     = now;
        send_req(req);
    endtask

    task automatic send_event(logic [3:0] kind, logic [1:0] media, logic [3:0] code);
        send_at(kind, media, code, next_time());
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_policy(t_cfg c);
        wait_idle();
        write_reg(REG_PROGRAM_MODE, 32'(c.program_mode));
        write_reg(REG_RETRY_TIMEOUT_MS, c.retry_timeout_ms);
        write_reg(REG_CHUNK_RETRY_LIMIT, 32'(c.chunk_retry_limit));
        write_reg(REG_LINK_FAIL_LIMIT, 32'(c.link_fail_limit));
        write_reg(REG_INIT_DATA_LIMIT, 32'(c.init_data_limit));
        write_reg(REG_DRM_FAIL_LIMIT, 32'(c.drm_fail_limit));
        write_reg(REG_UNSUPPORTED_LIMIT, 32'(c.unsupported_limit));
        policy_regs = c;
        n_settings++;
    endtask

    task automatic run_random(int count);
        int stop_at;
        int pick;
        int len;
        logic [1:0] med;
        logic [3:0] code;
        t_in_req noise;
        stop_at = n_sent + count;
        while (n_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, 8);
            if (pick < 55) begin
                med  = 2'($urandom_range(0, 3));
                code = pick_code();
                repeat (len) begin
                    if ($urandom_range(0, 9) == 0) code = pick_code();
                    send_event(EV_CHUNK_ERR, med, code);
                end
                if ($urandom_range(0, 3) != 0) begin
                    send_event(EV_CHUNK_OK, med, 4'($urandom_range(0, 15)));
                end
            end else if (pick < 67) begin
                repeat (len) send_event(EV_PLAYLIST_ERR, 2'($urandom_range(0, 3)),
                                        4'($urandom_range(0, 15)));
                if ($urandom_range(0, 3) != 0) send_event(EV_PLAYLIST_OK, MEDIA_AUDIO, CODE_NONE);
            end else if (pick < 77) begin
                repeat (len) send_event(EV_DRM_ERR, MEDIA_AUDIO, pick_code());
                if ($urandom_range(0, 3) != 0) send_event(EV_DRM_OK, MEDIA_AUDIO, CODE_NONE);
            end else if (pick < 86) begin
                repeat (len) send_event(EV_FORMAT_BAD, MEDIA_VIDEO, pick_code());
                if ($urandom_range(0, 3) != 0) send_event(EV_FORMAT_OK, MEDIA_VIDEO, CODE_NONE);
            end else if (pick < 90) begin
                send_event(EV_RESET_REC, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
            end else begin
                noise.event_kind = 4'($urandom_range(0, 15));
                noise.media_kind = 2'($urandom_range(0, 3));
                noise.error_code = 4'($urandom_range(0, 15));
                noise.now_ms     = $urandom();
                send_req(noise);
            end
        end
    endtask

    task automatic test_directed_events();
        send_at(EV_CHUNK_ERR, MEDIA_AUDIO, CODE_CONNECT, 32'd0);
        send_at(EV_CHUNK_ERR, MEDIA_AUDIO, CODE_CONNECT, DEFAULT_TIMEOUT);
        send_at(EV_CHUNK_OK, MEDIA_AUDIO, CODE_NONE, 32'hFFFF_FFFF);
        repeat (3) send_at(EV_CHUNK_ERR, MEDIA_VIDEO, CODE_LAST, 32'd1000);
        send_at(EV_CHUNK_ERR, MEDIA_SUBTITLE, CODE_NONE, 32'd2000);
        send_at(EV_PLAYLIST_ERR, MEDIA_AUDIO, CODE_AUTH, 32'd3000);
        send_at(EV_PLAYLIST_OK, MEDIA_AUDIO, CODE_NONE, 32'd4000);
        repeat (4) send_at(EV_CHUNK_ERR, MEDIA_INIT, CODE_SERVER, 32'd5000);
        send_at(EV_CHUNK_OK, MEDIA_INIT, CODE_NONE, 32'd6000);
        repeat (3) send_at(EV_DRM_ERR, MEDIA_AUDIO, CODE_SERVER, 32'd7000);
        send_at(EV_DRM_OK, MEDIA_AUDIO, CODE_NONE, 32'd8000);
        repeat (3) send_at(EV_FORMAT_BAD, MEDIA_VIDEO, CODE_SERVER, 32'd9000);
        send_at(EV_FORMAT_OK, MEDIA_VIDEO, CODE_NONE, 32'd10000);
        send_at(EV_RESET_REC, MEDIA_INIT, CODE_LAST, 32'd11000);
        send_at(EV_UNUSED_FIRST, MEDIA_VIDEO, CODE_CONNECT, 32'd12000);
        send_at(EV_UNUSED_LAST, MEDIA_INIT, CODE_LAST, 32'hFFFF_FFFF);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        set_policy('{MODE_OTHER_ALT, DEFAULT_TIMEOUT, 8'd3, 8'd10, 8'd3, 8'd3, 8'd3});
        send_event(EV_CHUNK_ERR, MEDIA_AUDIO, CODE_CONNECT);
        send_event(EV_CHUNK_ERR, MEDIA_VIDEO, CODE_SERVER);
        send_event(EV_PLAYLIST_ERR, MEDIA_AUDIO, CODE_NONE);
        send_event(EV_CHUNK_ERR, MEDIA_INIT, CODE_SERVER);

        set_policy('{MODE_OTHER, DEFAULT_TIMEOUT, 8'd1, 8'd1, 8'd0, 8'd1, 8'd1});
        send_event(EV_CHUNK_ERR, MEDIA_SUBTITLE, CODE_CONNECT);
        send_event(EV_CHUNK_ERR, MEDIA_VIDEO, CODE_LAST);
        send_event(EV_PLAYLIST_ERR, MEDIA_AUDIO, CODE_NONE);
        send_event(EV_CHUNK_ERR, MEDIA_INIT, CODE_SERVER);

        // Zero limits, a link limit of one and a zero timeout trip on the first error.
        set_policy('{MODE_VOD, 32'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0});
        send_event(EV_CHUNK_ERR, MEDIA_AUDIO, CODE_CONNECT);
        send_event(EV_CHUNK_ERR, MEDIA_VIDEO, CODE_SERVER);
        send_event(EV_PLAYLIST_ERR, MEDIA_AUDIO, CODE_NONE);
        send_event(EV_CHUNK_ERR, MEDIA_INIT, CODE_SERVER);
        send_event(EV_DRM_ERR, MEDIA_AUDIO, CODE_SERVER);
        send_event(EV_FORMAT_BAD, MEDIA_AUDIO, CODE_SERVER);

        set_policy('{MODE_LIVE, 32'hFFFF_FFFF, 8'd255, 8'd255, 8'd254, 8'd255, 8'd255});
        send_at(EV_CHUNK_ERR, MEDIA_SUBTITLE, CODE_SERVER, 32'hFFFF_FFF0);
        send_at(EV_CHUNK_ERR, MEDIA_SUBTITLE, CODE_CONNECT, 32'h0000_0005);
        repeat (2) send_event(EV_PLAYLIST_ERR, MEDIA_VIDEO, CODE_LAST);
        send_event(EV_DRM_ERR, MEDIA_AUDIO, CODE_NONE);
        send_event(EV_FORMAT_BAD, MEDIA_AUDIO, CODE_NONE);
        send_event(EV_CHUNK_ERR, MEDIA_INIT, CODE_NONE);

        set_policy('{MODE_LIVE, 32'd1, 8'd1, 8'd255, 8'd255, 8'd2, 8'd2});
        send_at(EV_CHUNK_ERR, MEDIA_AUDIO, CODE_SERVER, 32'hFFFF_FFFF);
        send_at(EV_CHUNK_ERR, MEDIA_AUDIO, CODE_SERVER, 32'hFFFF_FFFF);
        send_at(EV_CHUNK_ERR, MEDIA_AUDIO, CODE_SERVER, 32'h0000_0000);
        send_at(EV_CHUNK_OK, MEDIA_AUDIO, CODE_NONE, 32'h0000_0001);
        wait_idle();
    endtask

    task automatic test_random_phases();
        logic [1:0] modes[6];
        modes = '{MODE_VOD, MODE_LIVE, MODE_VOD, MODE_LIVE, MODE_OTHER, 2'($urandom_range(0, 3))};
        for (int p = 0; p < 6; p++) begin
            tx_idle_on = (p != 2);
            rx_idle_on = (p != 2) && (p != 3);
            now_cursor = (p == 4) ? 32'hFFFF_0000 : $urandom();
            set_policy(random_policy(modes[p]));
            run_random(100);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_counter_saturation();
        t_cfg c;
        c = random_policy(MODE_LIVE);
        c.drm_fail_limit = 8'd255;
        set_policy(c);
        repeat (262) send_event(EV_DRM_ERR, MEDIA_AUDIO, pick_code());
        send_event(EV_DRM_OK, MEDIA_AUDIO, CODE_NONE);
        wait_idle();
    endtask

    task automatic test_flow_control();
        set_policy(random_policy(MODE_VOD));
        tx_idle_on = 1'b0;
        rx_hold_reqs++;
        run_random(20);
        tx_idle_on = 1'b1;
        run_random(8);
        wait_idle();
        run_random(8);
        wait_idle();
    endtask

    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected result: verdict %0d, retry_interval_ms %0d",
                       o_out_data.verdict, o_out_data.retry_interval_ms);
                n_err++;
            end else begin
                want = pending_verdicts.pop_front();
                n_checked++;
                if (o_out_data.verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, o_out_data.verdict);
                    n_err++;
                end
                if (o_out_data.retry_interval_ms !== want.retry_interval_ms) begin
                    $error("retry_interval_ms: expected %0d, got %0d",
                           want.retry_interval_ms, o_out_data.retry_interval_ms);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : rx_driver
        int len;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_reqs != rx_hold_served) begin
                rx_hold_served++;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (rx_idle_on) begin
                len = idle_len();
                if (len > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (len) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 6)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_in_data    <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        now_cursor   = '0;
        reset_policy_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_events();
        test_register_extremes();
        test_random_phases();
        test_counter_saturation();
        test_flow_control();

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d requests and %0d compared results over %0d register settings.",
                 n_sent, n_checked, n_settings);
        $display("Included on-demand, live and other modes, zero and full-scale limits, "
                 , "time wrap, counter saturation and a long output hold-off.");
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[stream_error_retry_policy.f]
src/serp_pkg.sv
src/serp_cfg.sv
src/serp_core.sv
src/stream_error_retry_policy.sv
src/serp_checker.sv
sim/tb.sv
